FILE: rtl/iqpd_pkg.sv
// ----------------------------------------------------------------------------
// iqpd_pkg
// Shared types, constants and the arctangent table of the I/Q phase block.
// ----------------------------------------------------------------------------
package iqpd_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_STAGES_DEF = 16;

  // The arctangent table holds this many entries, so no more stages can run.
  localparam int TABLE_LEN = 24;

  // Angle accumulator: degrees with 24 fraction bits, up to about +/-190 degrees.
  localparam int ANG_FRAC    = 24;
  localparam int ANGLE_WIDTH = 33;

  // Output: 1/256 degree steps, so 16 fraction bits are rounded away.
  localparam int OUT_SHIFT   = ANG_FRAC - 8;
  localparam int PHASE_WIDTH = 17;
  localparam int HALF_TURN   = 180;
  localparam int PHASE_MAX   = HALF_TURN * 256;
  localparam int PHASE_QUART = PHASE_MAX / 2;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [PHASE_WIDTH-1:0] phase_t;

  // Ninety degrees on the accumulator scale.
  localparam angle_t QUARTER_TURN = angle_t'((HALF_TURN / 2) * (64'd1 << ANG_FRAC));

  // Side information that rides along with each word through the pipeline.
  // When special is set, phase holds the final answer for an axis input.
  typedef struct packed {
    logic   special;
    phase_t phase;
  } side_t;

  // atan(2^-idx) in degrees, times 2^24, rounded to nearest.
  function automatic angle_t atan_entry(input int unsigned idx);
    angle_t val;
    case (idx)
      0:       val = angle_t'(754974720);
      1:       val = angle_t'(445687602);
      2:       val = angle_t'(235489088);
      3:       val = angle_t'(119537938);
      4:       val = angle_t'(60000934);
      5:       val = angle_t'(30029717);
      6:       val = angle_t'(15018523);
      7:       val = angle_t'(7509719);
      8:       val = angle_t'(3754917);
      9:       val = angle_t'(1877466);
      10:      val = angle_t'(938734);
      11:      val = angle_t'(469367);
      12:      val = angle_t'(234684);
      13:      val = angle_t'(117342);
      14:      val = angle_t'(58671);
      15:      val = angle_t'(29335);
      16:      val = angle_t'(14668);
      17:      val = angle_t'(7334);
      18:      val = angle_t'(3667);
      19:      val = angle_t'(1833);
      20:      val = angle_t'(917);
      21:      val = angle_t'(458);
      22:      val = angle_t'(229);
      23:      val = angle_t'(115);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/iqpd_prerot.sv
// ----------------------------------------------------------------------------
// iqpd_prerot
// Input stage: scales the samples, folds the vector into the right half plane
// and flags inputs that lie on an axis.
// ----------------------------------------------------------------------------
module iqpd_prerot #(
  parameter int SAMPLE_WIDTH = iqpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_STAGES = iqpd_pkg::ANGLE_STAGES_DEF,
  localparam int XWIDTH      = SAMPLE_WIDTH + ANGLE_STAGES + 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample_i,
  output logic                           valid_o,
  output logic signed [XWIDTH-1:0]       x_o,
  output logic signed [XWIDTH-1:0]       y_o,
  output iqpd_pkg::angle_t               z_o,
  output iqpd_pkg::side_t                side_o
);

  logic signed [XWIDTH-1:0] i_ext, q_ext;
  logic signed [XWIDTH-1:0] x_d, y_d, x_q, y_q;
  iqpd_pkg::angle_t         z_d, z_q;
  iqpd_pkg::side_t          side_d, side_q;
  logic                     valid_q;
  logic                     i_zero, q_zero, i_neg, q_neg;

  assign i_ext  = {{2{i_sample_i[SAMPLE_WIDTH-1]}}, i_sample_i, {ANGLE_STAGES{1'b0}}};
  assign q_ext  = {{2{q_sample_i[SAMPLE_WIDTH-1]}}, q_sample_i, {ANGLE_STAGES{1'b0}}};
  assign i_zero = (i_sample_i == '0);
  assign q_zero = (q_sample_i == '0);
  assign i_neg  = i_sample_i[SAMPLE_WIDTH-1];
  assign q_neg  = q_sample_i[SAMPLE_WIDTH-1];

  always_comb begin
    if (q_neg && !i_neg) begin
      x_d = i_ext;
      y_d = -q_ext;
      z_d = iqpd_pkg::QUARTER_TURN;
    end else if (q_neg) begin
      x_d = -i_ext;
      y_d = q_ext;
      z_d = -iqpd_pkg::QUARTER_TURN;
    end else begin
      x_d = q_ext;
      y_d = i_ext;
      z_d = '0;
    end
  end

  always_comb begin
    side_d.special = i_zero || q_zero;
    if (i_zero) begin
      side_d.phase = q_neg ? iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX) : '0;
    end else if (i_neg) begin
      side_d.phase = -iqpd_pkg::phase_t'(iqpd_pkg::PHASE_QUART);
    end else begin
      side_d.phase = iqpd_pkg::phase_t'(iqpd_pkg::PHASE_QUART);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/iqpd_stage.sv
// ----------------------------------------------------------------------------
// iqpd_stage
// One registered vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module iqpd_stage #(
  parameter int XWIDTH = 34,
  parameter int SHIFT  = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [XWIDTH-1:0] x_i,
  input  logic signed [XWIDTH-1:0] y_i,
  input  iqpd_pkg::angle_t         z_i,
  input  iqpd_pkg::side_t          side_i,
  output logic                     valid_o,
  output logic signed [XWIDTH-1:0] x_o,
  output logic signed [XWIDTH-1:0] y_o,
  output iqpd_pkg::angle_t         z_o,
  output iqpd_pkg::side_t          side_o
);

  localparam iqpd_pkg::angle_t STEP = iqpd_pkg::atan_entry(SHIFT);

  logic signed [XWIDTH-1:0] dx, dy, x_d, y_d, x_q, y_q;
  iqpd_pkg::angle_t         z_d, z_q;
  iqpd_pkg::side_t          side_q;
  logic                     valid_q;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;

  // Rotate toward the positive x axis; y sign picks the direction.
  always_comb begin
    if (!y_i[XWIDTH-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + STEP;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/iqpd_round.sv
// ----------------------------------------------------------------------------
// iqpd_round
// Output stage: rounds the accumulated angle to 1/256 degree, saturates it
// and substitutes the answer for axis inputs.
// ----------------------------------------------------------------------------
module iqpd_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  iqpd_pkg::angle_t z_i,
  input  iqpd_pkg::side_t  side_i,
  output logic             done_o,
  output iqpd_pkg::phase_t phase_o
);

  localparam int RWIDTH = iqpd_pkg::ANGLE_WIDTH - iqpd_pkg::OUT_SHIFT;
  localparam iqpd_pkg::angle_t HALF_LSB = iqpd_pkg::angle_t'(64'd1 << (iqpd_pkg::OUT_SHIFT - 1));
  localparam logic signed [RWIDTH-1:0] SAT_HI = RWIDTH'(iqpd_pkg::PHASE_MAX);
  localparam logic signed [RWIDTH-1:0] SAT_LO = -SAT_HI;

  iqpd_pkg::angle_t         z_bias;
  logic signed [RWIDTH-1:0] rnd, sat;
  iqpd_pkg::phase_t         phase_d, phase_q;
  logic                     done_q;

  assign z_bias = z_i + HALF_LSB;
  assign rnd    = z_bias[iqpd_pkg::ANGLE_WIDTH-1:iqpd_pkg::OUT_SHIFT];

  always_comb begin
    if (rnd > SAT_HI) begin
      sat = SAT_HI;
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = rnd;
    end
    phase_d = side_i.special ? side_i.phase : iqpd_pkg::phase_t'(sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
  end

  assign done_o  = done_q;
  assign phase_o = phase_q;

endmodule

FILE: rtl/iq_phase_degrees.sv
// ----------------------------------------------------------------------------
// iq_phase_degrees
// Phase of an I/Q sample pair in 1/256 degree, by a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// The block takes one word per clock and never stalls: busy is always low, so
// every cycle with start high hands in an I/Q pair. The phase is atan2 with I
// as the y operand and Q as the x operand, in steps of 1/256 degree from -180
// to +180 degrees, rounded to nearest. The result comes out on phase_o for one
// cycle with done_o high, once the word has passed the input fold register,
// one register per micro-rotation and the rounding register. The receiver
// cannot hold results off and none are ever buffered, so it must take each
// word in the cycle that done_o marks. Inputs that lie on an axis bypass the
// rotations: I zero with Q not negative gives 0, I zero with Q negative gives
// +180 degrees, and Q zero gives +90 or -90 degrees by the sign of I.
// ----------------------------------------------------------------------------
module iq_phase_degrees #(
  parameter int SAMPLE_WIDTH = iqpd_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_STAGES = iqpd_pkg::ANGLE_STAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample_i,
  output logic                           done_o,
  output iqpd_pkg::phase_t               phase_o
);

  // Only as many stages as the table has entries can run.
  localparam int NUM_STAGES = (ANGLE_STAGES < iqpd_pkg::TABLE_LEN) ?
                              ANGLE_STAGES : iqpd_pkg::TABLE_LEN;
  // Headroom: one bit for negating the most negative sample, one for the
  // CORDIC gain times the square root of two.
  localparam int XWIDTH  = SAMPLE_WIDTH + NUM_STAGES + 2;
  localparam int LATENCY = NUM_STAGES + 2;

  logic                     accept;
  logic                     valid_s [NUM_STAGES+1];
  logic signed [XWIDTH-1:0] x_s     [NUM_STAGES+1];
  logic signed [XWIDTH-1:0] y_s     [NUM_STAGES+1];
  iqpd_pkg::angle_t         z_s     [NUM_STAGES+1];
  iqpd_pkg::side_t          side_s  [NUM_STAGES+1];

  // The pipeline moves every cycle, so a new word is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  iqpd_prerot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ANGLE_STAGES (NUM_STAGES)
  ) u_prerot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .i_sample_i (i_sample_i),
    .q_sample_i (q_sample_i),
    .valid_o    (valid_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .z_o        (z_s[0]),
    .side_o     (side_s[0])
  );

  // One micro-rotation per register stage; stage k shifts by k.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    iqpd_stage #(
      .XWIDTH (XWIDTH),
      .SHIFT  (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .x_i     (x_s[k]),
      .y_i     (y_s[k]),
      .z_i     (z_s[k]),
      .side_i  (side_s[k]),
      .valid_o (valid_s[k+1]),
      .x_o     (x_s[k+1]),
      .y_o     (y_s[k+1]),
      .z_o     (z_s[k+1]),
      .side_o  (side_s[k+1])
    );
  end

  // Only the angle is needed at the end; the final x and y are dropped.
  iqpd_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NUM_STAGES]),
    .z_i     (z_s[NUM_STAGES]),
    .side_i  (side_s[NUM_STAGES]),
    .done_o  (done_o),
    .phase_o (phase_o)
  );

  // Every accepted word yields its result after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result strobe missing after accepted word");

  // No result appears without a word accepted the fixed latency earlier.
  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without matching accepted word");

  // Saturation keeps every result within one half turn.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (phase_o <= iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX)) &&
               (phase_o >= -iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX)))
    else $error("phase outside +/-180 degrees");

  // I zero with Q negative bypasses the rotations and reads +180 degrees.
  a_neg_axis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (i_sample_i == '0) && q_sample_i[SAMPLE_WIDTH-1])
    |-> ##LATENCY (phase_o == iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX)))
    else $error("negative Q axis does not give +180 degrees");

  // Q zero with I positive reads exactly +90 degrees.
  a_pos_quarter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (q_sample_i == '0) && (i_sample_i != '0) && !i_sample_i[SAMPLE_WIDTH-1])
    |-> ##LATENCY (phase_o == iqpd_pkg::phase_t'(iqpd_pkg::PHASE_QUART)))
    else $error("positive I axis does not give +90 degrees");

endmodule

FILE: sim/iq_phase_degrees_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iq_phase_degrees_tb
// Self-checking bench for the I/Q phase block: directed axis and corner
// words first, then a long random stream, checked against typed-in phases
// for the directed axis words and a local CORDIC phase predictor otherwise.
// ----------------------------------------------------------------------------
module iq_phase_degrees_tb;

  // The instance runs with these values. The predictor uses the same values.
  localparam int SW     = 16;
  localparam int STAGES = 16;

  // Rotations actually run: the arctangent table stops at 24 entries.
  localparam int RUN_STAGES = (STAGES < 24) ? STAGES : 24;

  // Pipeline depth: the fold register, the rotation registers and the rounding register.
  localparam int LATENCY = RUN_STAGES + 2;

  // The watchdog gives up after this many cycles in which no word went in
  // and no result came out. The longest correct quiet stretch is a sender
  // gap plus the pipeline depth, far below this.
  localparam int QUIET_LIMIT = 2000;

  localparam int NUM_RANDOM = 1200;
  localparam int NUM_DIRECT = 23;

  // atan(2^-k) in degrees with 24 fraction bits, rounded to nearest.
  localparam longint ATAN_DEG [0:23] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509719,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115
  };

  typedef logic signed [SW-1:0] sample_t;

  // One row of the directed table. Where known_phase is set, the expected
  // phase is typed in; otherwise the predictor supplies it.
  typedef struct {
    sample_t i_val;
    sample_t q_val;
    bit      known_phase;
    int      phase_val;
  } direct_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  sample_t          i_sample_i;
  sample_t          q_sample_i;
  logic             done_o;
  iqpd_pkg::phase_t phase_o;

  // Travels with the driven word so the monitor knows whether the directed
  // table gave an exact answer for it.
  bit               drv_known;
  iqpd_pkg::phase_t drv_phase;

  iqpd_pkg::phase_t phase_q [$];   // expected phases, oldest first
  int               err_cnt;
  int               quiet_cycles;

  iq_phase_degrees #(
    .SAMPLE_WIDTH (SW),
    .ANGLE_STAGES (STAGES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .i_sample_i (i_sample_i),
    .q_sample_i (q_sample_i),
    .done_o     (done_o),
    .phase_o    (phase_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Phase predictor: atan2 with I as y and Q as x, by a vectoring CORDIC.
  // The angle runs in degrees with 24 fraction bits and is rounded to
  // 1/256 degree with ties toward plus infinity, then clamped to +/-180.
  function automatic iqpd_pkg::phase_t cordic_phase(sample_t y_in, sample_t x_in);
    longint x;
    longint y;
    longint z;
    longint tmp;
    longint dx;
    longint dy;
    longint r;
    // Samples on an axis never reach the rotations.
    if (y_in == 0) begin
      return (x_in < 0) ? iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX) : iqpd_pkg::phase_t'(0);
    end
    if (x_in == 0) begin
      return (y_in > 0) ? iqpd_pkg::phase_t'(iqpd_pkg::PHASE_MAX / 2)
                        : iqpd_pkg::phase_t'(-(iqpd_pkg::PHASE_MAX / 2));
    end
    x = longint'(x_in) <<< RUN_STAGES;
    y = longint'(y_in) <<< RUN_STAGES;
    z = 0;
    // Fold a left-half-plane vector into the right half by a quarter turn.
    if (x < 0) begin
      tmp = x;
      if (y >= 0) begin
        x = y;
        y = -tmp;
        z = longint'(90) <<< 24;
      end else begin
        x = -y;
        y = tmp;
        z = -(longint'(90) <<< 24);
      end
    end
    for (int k = 0; k < RUN_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_DEG[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_DEG[k];
      end
    end
    r = (z + (longint'(1) <<< 15)) >>> 16;
    if (r > iqpd_pkg::PHASE_MAX) r = iqpd_pkg::PHASE_MAX;
    if (r < -iqpd_pkg::PHASE_MAX) r = -iqpd_pkg::PHASE_MAX;
    return iqpd_pkg::phase_t'(r);
  endfunction

  // Monitor. Inputs are driven with nonblocking assignments at the rising
  // edge, so everything read here is the value that held before the edge.
  // A result is checked before the word taken at the same edge is queued,
  // because that word's answer cannot be older than anything waiting.
  always @(posedge clk_i) begin
    iqpd_pkg::phase_t want;
    logic             took;
    took = rst_ni && start && !busy;
    if (rst_ni && done_o) begin
      if (phase_q.size() == 0) begin
        $display("%0t: result with nothing expected, got phase %0d", $time, phase_o);
        err_cnt++;
      end else begin
        want = phase_q.pop_front();
        if (phase_o !== want) begin
          $display("%0t: phase mismatch, expected %0d, got %0d", $time, want, phase_o);
          err_cnt++;
        end
      end
    end
    if (took) begin
      phase_q.push_back(drv_known ? drv_phase : cordic_phase(i_sample_i, q_sample_i));
    end
    if (took || (rst_ni && done_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: ends the run if the block goes silent for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Stimulus.
  initial begin
    direct_row_t rows [NUM_DIRECT];
    int          burst_left;
    int          gap;
    sample_t     ri;
    sample_t     rq;
    int          mag;

    // Axis words have exact answers; the corners and the words next to the
    // axes go through the rotations and are left to the predictor.
    rows = '{
      '{16'sd0,      16'sd0,      1'b1, 0},
      '{16'sd0,      16'sd5,      1'b1, 0},
      '{16'sd0,      16'sd32767,  1'b1, 0},
      '{16'sd0,      -16'sd1,     1'b1, iqpd_pkg::PHASE_MAX},
      '{16'sd0,      -16'sd32768, 1'b1, iqpd_pkg::PHASE_MAX},
      '{16'sd1,      16'sd0,      1'b1, iqpd_pkg::PHASE_MAX / 2},
      '{16'sd32767,  16'sd0,      1'b1, iqpd_pkg::PHASE_MAX / 2},
      '{-16'sd1,     16'sd0,      1'b1, -(iqpd_pkg::PHASE_MAX / 2)},
      '{-16'sd32768, 16'sd0,      1'b1, -(iqpd_pkg::PHASE_MAX / 2)},
      '{16'sd32767,  16'sd32767,  1'b0, 0},
      '{-16'sd32768, -16'sd32768, 1'b0, 0},
      '{16'sd32767,  -16'sd32768, 1'b0, 0},
      '{-16'sd32768, 16'sd32767,  1'b0, 0},
      '{16'sd1,      16'sd1,      1'b0, 0},
      '{-16'sd1,     -16'sd1,     1'b0, 0},
      '{16'sd1,      -16'sd1,     1'b0, 0},
      '{-16'sd1,     16'sd1,      1'b0, 0},
      '{16'sd1,      -16'sd32768, 1'b0, 0},
      '{-16'sd1,     -16'sd32768, 1'b0, 0},
      '{16'sd32767,  16'sd1,      1'b0, 0},
      '{-16'sd32768, -16'sd1,     1'b0, 0},
      '{16'sd1,      16'sd32767,  1'b0, 0},
      '{-16'sd1,     16'sd32767,  1'b0, 0}
    };

    err_cnt      = 0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    i_sample_i   = '0;
    q_sample_i   = '0;
    drv_known    = 1'b0;
    drv_phase    = '0;
    burst_left   = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_DIRECT + NUM_RANDOM; n++) begin
      // Between bursts the sender goes quiet for a while and puts noise on
      // the sample ports, which the block must ignore. Gap lengths span the
      // whole pipeline so that holes land on every stage.
      if (burst_left == 0) begin
        gap = $urandom_range(1, LATENCY + 4);
        repeat (gap) begin
          start      <= 1'b0;
          i_sample_i <= sample_t'($urandom);
          q_sample_i <= sample_t'($urandom);
          @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
      end
      burst_left--;

      if (n < NUM_DIRECT) begin
        ri = rows[n].i_val;
        rq = rows[n].q_val;
        drv_known <= rows[n].known_phase;
        drv_phase <= iqpd_pkg::phase_t'(rows[n].phase_val);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            ri = sample_t'($urandom);
            rq = sample_t'($urandom);
          end
          4: begin
            ri = sample_t'($urandom_range(0, 8) - 4);
            rq = sample_t'($urandom_range(0, 8) - 4);
          end
          5: begin
            ri = '0;
            rq = sample_t'($urandom);
          end
          6: begin
            ri = sample_t'($urandom);
            rq = '0;
          end
          7: begin
            // Full-scale values on both operands, shifted right by 0 to 15 bits down to unit or zero.
            ri = (($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff)
                 >>> $urandom_range(0, 15);
            rq = (($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff)
                 >>> $urandom_range(0, 15);
          end
          8: begin
            // Close to the negative Q axis, where the angle nears +/-180 and
            // the clamp can act.
            ri = sample_t'($urandom_range(0, 6) - 3);
            rq = sample_t'(-$urandom_range(1, 32768));
          end
          default: begin
            // On the diagonals, where the fold and the first rotation meet.
            mag = $urandom_range(1, 32767);
            ri  = ($urandom_range(0, 1) == 0) ? sample_t'(mag) : sample_t'(-mag);
            rq  = ($urandom_range(0, 1) == 0) ? sample_t'(mag) : sample_t'(-mag);
          end
        endcase
        drv_known <= 1'b0;
      end

      start      <= 1'b1;
      i_sample_i <= ri;
      q_sample_i <= rq;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
    end

    start <= 1'b0;
    @(posedge clk_i);
    // The watchdog catches a block that never drains.
    while (phase_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/iqpd_pkg.sv
rtl/iqpd_prerot.sv
rtl/iqpd_stage.sv
rtl/iqpd_round.sv
rtl/iq_phase_degrees.sv
sim/iq_phase_degrees_tb.sv
